>>> src/refraction_direction_unit_assert.svh
// Assertion macros for the refraction direction unit
`ifndef REFRACTION_DIRECTION_UNIT_ASSERT_SVH
`define REFRACTION_DIRECTION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RDU_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdu assertion failed");
`define RDU_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdu assertion failed");
`else
`define RDU_ASSERT_IMP(name, clk, rst, ante, cons)
`define RDU_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> src/rdu_pkg.sv
// Types and constants shared by the refraction direction unit
package rdu_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } ray_t;

  typedef struct packed {
    logic               total_reflect;
    logic signed [15:0] trans_x;
    logic signed [15:0] trans_y;
    logic signed [15:0] trans_z;
    logic        [15:0] trans_scale;
  } res_t;

  // sideband carried alongside the square root
  typedef struct packed {
    ray_t        ray;
    logic        leave;
    logic        tir;
    logic [38:0] ce;
    logic [29:0] esq;
  } side_t;

  localparam logic [1:0] CFG_INDEX_RATIO   = 2'd0;
  localparam logic [1:0] CFG_INDEX_INVERSE = 2'd1;
  localparam logic [1:0] CFG_TRANS_COEFF   = 2'd2;

  localparam logic [14:0] RST_INDEX_RATIO   = 15'd6144;
  localparam logic [14:0] RST_INDEX_INVERSE = 15'd2731;
  localparam logic [15:0] RST_TRANS_COEFF   = 16'd32768;

  localparam int ROOT_BITS = 31;
  localparam int RAD_W     = 62;
  localparam int QUO_BITS  = 16;
  localparam int NUM_W     = 46;
  localparam int DEN_W     = 35;

endpackage

>>> src/rdu_sqrt.sv
// Pipelined integer square root, one result bit per stage
module rdu_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [rdu_pkg::RAD_W-1:0]         radicand,
  input  rdu_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic [rdu_pkg::ROOT_BITS-1:0]     root,
  output rdu_pkg::side_t                    out_side
);
  import rdu_pkg::*;

  logic [RAD_W-1:0]     rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] res_q  [ROOT_BITS];
  logic                 vld_q  [ROOT_BITS];
  side_t                side_q [ROOT_BITS];

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_step
    localparam int K = ROOT_BITS - 1 - g;
    logic [RAD_W-1:0]     rem_i;
    logic [ROOT_BITS-1:0] res_i;
    logic                 vld_i;
    side_t                side_i;
    logic [63:0]          trial;

    if (g == 0) begin : g_first
      assign rem_i  = radicand;
      assign res_i  = '0;
      assign vld_i  = in_valid;
      assign side_i = in_side;
    end else begin : g_rest
      assign rem_i  = rem_q[g-1];
      assign res_i  = res_q[g-1];
      assign vld_i  = vld_q[g-1];
      assign side_i = side_q[g-1];
    end

    // (r + 2^K)^2 - r^2
    assign trial = ({{(64-ROOT_BITS){1'b0}}, res_i} << (K + 1)) + (64'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[g] <= side_i;
        if ({{(64-RAD_W){1'b0}}, rem_i} >= trial) begin
          rem_q[g] <= rem_i - trial[RAD_W-1:0];
          res_q[g] <= res_i | (ROOT_BITS'(1) << K);
        end else begin
          rem_q[g] <= rem_i;
          res_q[g] <= res_i;
        end
      end
    end
  end

  assign out_valid = vld_q[ROOT_BITS-1];
  assign root      = res_q[ROOT_BITS-1];
  assign out_side  = side_q[ROOT_BITS-1];

endmodule

>>> src/rdu_div.sv
// Pipelined saturating quotient for the transmission scale
module rdu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rdu_pkg::NUM_W-1:0]     num,
  input  logic [rdu_pkg::DEN_W-1:0]     den,
  input  rdu_pkg::res_t                 in_side,
  output logic                          out_valid,
  output rdu_pkg::res_t                 out_res
);
  import rdu_pkg::*;

  localparam int CMP_W = DEN_W + QUO_BITS;

  logic                v0;
  logic                sat0;
  logic [NUM_W-1:0]    rem0;
  logic [DEN_W-1:0]    den0;
  res_t                side0;

  logic                vld_q  [QUO_BITS];
  logic                sat_q  [QUO_BITS];
  logic [NUM_W-1:0]    rem_q  [QUO_BITS];
  logic [DEN_W-1:0]    den_q  [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q  [QUO_BITS];
  res_t                side_q [QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  // quotient at or above full scale, zero divisor included
  always_ff @(posedge clk) begin
    if (en) begin
      sat0  <= {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {QUO_BITS{1'b0}}};
      rem0  <= num;
      den0  <= den;
      side0 <= in_side;
    end
  end

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
    localparam int J = QUO_BITS - 1 - g;
    logic                vld_i;
    logic                sat_i;
    logic [NUM_W-1:0]    rem_i;
    logic [DEN_W-1:0]    den_i;
    logic [QUO_BITS-1:0] quo_i;
    res_t                side_i;
    logic [CMP_W-1:0]    trial;

    if (g == 0) begin : g_first
      assign vld_i  = v0;
      assign sat_i  = sat0;
      assign rem_i  = rem0;
      assign den_i  = den0;
      assign quo_i  = '0;
      assign side_i = side0;
    end else begin : g_rest
      assign vld_i  = vld_q[g-1];
      assign sat_i  = sat_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign den_i  = den_q[g-1];
      assign quo_i  = quo_q[g-1];
      assign side_i = side_q[g-1];
    end

    assign trial = {{QUO_BITS{1'b0}}, den_i} << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_q[g]  <= sat_i;
        den_q[g]  <= den_i;
        side_q[g] <= side_i;
        if ({{(CMP_W-NUM_W){1'b0}}, rem_i} >= trial) begin
          rem_q[g] <= rem_i - trial[NUM_W-1:0];
          quo_q[g] <= quo_i | (QUO_BITS'(1) << J);
        end else begin
          rem_q[g] <= rem_i;
          quo_q[g] <= quo_i;
        end
      end
    end
  end

  always_comb begin
    out_res = side_q[QUO_BITS-1];
    if (side_q[QUO_BITS-1].total_reflect) begin
      out_res.trans_scale = '0;
    end else if (sat_q[QUO_BITS-1]) begin
      out_res.trans_scale = '1;
    end else begin
      out_res.trans_scale = quo_q[QUO_BITS-1];
    end
  end

  assign out_valid = vld_q[QUO_BITS-1];

endmodule

>>> src/refraction_direction_unit.sv
// Refraction direction unit: Snell transmitted direction and transmission scale.
// One ray per cycle unless ray_stall is high.
// The depth is set by the square root (31 stages, one root bit each) and the
// scale quotient (17 stages: a saturation compare, then one quotient bit each).
// The whole pipeline holds while a result waits on res_stall.
// Synchronous reset clears the valid bits and loads the register defaults.
`include "refraction_direction_unit_assert.svh"

module refraction_direction_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           ray_valid,
  output logic           ray_stall,
  input  rdu_pkg::ray_t  ray,
  output logic           res_valid,
  input  logic           res_stall,
  output rdu_pkg::res_t  res,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import rdu_pkg::*;

  logic        adv;
  logic [14:0] index_ratio;
  logic [14:0] index_ratio_inverse;
  logic [15:0] transmission_coeff;

  assign adv       = !(res_valid && res_stall);
  assign ray_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_ratio         <= RST_INDEX_RATIO;
      index_ratio_inverse <= RST_INDEX_INVERSE;
      transmission_coeff  <= RST_TRANS_COEFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INDEX_RATIO:   index_ratio         <= cfg_data[14:0];
        CFG_INDEX_INVERSE: index_ratio_inverse <= cfg_data[14:0];
        CFG_TRANS_COEFF:   transmission_coeff  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: component products of d.n
  logic               v1;
  ray_t               r1;
  logic signed [31:0] p1x, p1y, p1z;

  // stage 2: incidence cosine
  logic               v2;
  ray_t               r2;
  logic               leave2;
  logic [23:0]        c20_2;
  logic signed [33:0] dsum;
  logic [33:0]        cabs;

  // stage 3
  logic               v3;
  ray_t               r3;
  logic               leave3;
  logic [47:0]        c20sq3;
  logic [38:0]        ce3;
  logic [29:0]        esq3;
  logic [14:0]        e2;

  // stage 4
  logic               v4;
  ray_t               r4;
  logic               leave4;
  logic signed [33:0] om4;
  logic [38:0]        ce4;
  logic [29:0]        esq4;
  logic signed [49:0] om40;

  // stage 5
  logic               v5;
  ray_t               r5;
  logic               leave5;
  logic signed [63:0] prod5;
  logic [38:0]        ce5;
  logic [29:0]        esq5;

  // stage 6: discriminant
  logic               v6;
  logic [RAD_W-1:0]   rad6;
  side_t              side6;
  logic signed [63:0] disc;

  logic                 sq_valid;
  logic [ROOT_BITS-1:0] sq_root;
  side_t                sq_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= ray_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign dsum = 34'(p1x) + 34'(p1y) + 34'(p1z);
  assign cabs = (dsum > 0) ? dsum : -dsum;
  assign e2   = leave2 ? index_ratio : index_ratio_inverse;
  assign om40 = (50'sd1 <<< 40) - $signed({2'b00, c20sq3});
  assign disc = (64'sd1 <<< 48) - prod5;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1  <= ray;
      p1x <= ray.dir_x * ray.norm_x;
      p1y <= ray.dir_y * ray.norm_y;
      p1z <= ray.dir_z * ray.norm_z;

      r2     <= r1;
      leave2 <= dsum > 0;  // grazing counts as entering
      c20_2  <= cabs[31:8];

      r3     <= r2;
      leave3 <= leave2;
      c20sq3 <= c20_2 * c20_2;
      ce3    <= c20_2 * e2;
      esq3   <= e2 * e2;

      r4     <= r3;
      leave4 <= leave3;
      om4    <= om40[49:16];
      ce4    <= ce3;
      esq4   <= esq3;

      r5     <= r4;
      leave5 <= leave4;
      prod5  <= $signed({1'b0, esq4}) * om4;
      ce5    <= ce4;
      esq5   <= esq4;

      rad6        <= disc[63] ? '0 : disc[RAD_W-1:0];
      side6.ray   <= r5;
      side6.leave <= leave5;
      side6.tir   <= disc[63];
      side6.ce    <= ce5;
      side6.esq   <= esq5;
    end
  end

  rdu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .radicand  (rad6),
    .in_side   (side6),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // stage 7: k = cos_t - c/eta'
  logic               v7;
  side_t              s7;
  logic signed [40:0] k7;

  // stage 8: lane products
  logic               v8;
  logic               tir8;
  logic [29:0]        esq8;
  logic signed [15:0] n8  [3];
  logic signed [31:0] de8 [3];
  logic signed [57:0] nk8 [3];
  logic signed [15:0] d7  [3];
  logic signed [15:0] n7  [3];
  logic signed [16:0] nl7 [3];
  logic [14:0]        e7;

  // stage 9: rounded, saturated direction
  logic               v9;
  logic               tir9;
  logic [29:0]        esq9;
  logic signed [15:0] n9  [3];
  logic signed [15:0] t9  [3];
  logic signed [59:0] w8  [3];
  logic signed [27:0] q8  [3];

  // stage 10: n.t products
  logic               v10;
  logic               tir10;
  logic [29:0]        esq10;
  logic signed [15:0] t10 [3];
  logic signed [31:0] np10 [3];

  // stage 11: quotient operands
  logic               v11;
  logic [NUM_W-1:0]   num11;
  logic [DEN_W-1:0]   den11;
  res_t               side11;
  logic signed [33:0] ntsum;
  logic [33:0]        ntabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else if (adv) begin
      v7  <= sq_valid;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
    end
  end

  assign d7[0] = s7.ray.dir_x;
  assign d7[1] = s7.ray.dir_y;
  assign d7[2] = s7.ray.dir_z;
  assign n7[0] = s7.ray.norm_x;
  assign n7[1] = s7.ray.norm_y;
  assign n7[2] = s7.ray.norm_z;
  assign e7    = s7.leave ? index_ratio : index_ratio_inverse;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nl7[i] = s7.leave ? -17'(n7[i]) : 17'(n7[i]);
      w8[i]  = (60'(de8[i]) <<< 20) - 60'(nk8[i]) + (60'sd1 <<< 31);
      q8[i]  = w8[i][59:32];
    end
  end

  assign ntsum = 34'(np10[0]) + 34'(np10[1]) + 34'(np10[2]);
  assign ntabs = ntsum[33] ? -ntsum : ntsum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7 <= sq_side;
      k7 <= $signed({2'b00, sq_root, 8'h00}) - $signed({2'b00, sq_side.ce});

      tir8 <= s7.tir;
      esq8 <= s7.esq;
      for (int i = 0; i < 3; i++) begin
        n8[i]  <= n7[i];
        de8[i] <= d7[i] * $signed({1'b0, e7});
        nk8[i] <= nl7[i] * k7;
      end

      tir9 <= tir8;
      esq9 <= esq8;
      for (int i = 0; i < 3; i++) begin
        n9[i] <= n8[i];
        if (q8[i] > 28'sd32767) begin
          t9[i] <= 16'sh7fff;
        end else if (q8[i] < -28'sd32768) begin
          t9[i] <= -16'sh8000;
        end else begin
          t9[i] <= q8[i][15:0];
        end
      end

      tir10 <= tir9;
      esq10 <= esq9;
      for (int i = 0; i < 3; i++) begin
        t10[i]  <= t9[i];
        np10[i] <= n9[i] * t9[i];
      end

      num11                <= transmission_coeff * esq10;
      den11                <= {ntabs[31:0], 3'b000};
      side11.total_reflect <= tir10;
      side11.trans_x       <= tir10 ? '0 : t10[0];
      side11.trans_y       <= tir10 ? '0 : t10[1];
      side11.trans_z       <= tir10 ? '0 : t10[2];
      side11.trans_scale   <= '0;
    end
  end

  rdu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v11),
    .num       (num11),
    .den       (den11),
    .in_side   (side11),
    .out_valid (res_valid),
    .out_res   (res)
  );

  `RDU_ASSERT_IMP(a_tir_zero, clk, rst, res_valid && res.total_reflect, res.trans_x == 16'sd0 && res.trans_y == 16'sd0 && res.trans_z == 16'sd0 && res.trans_scale == 16'd0)
  `RDU_ASSERT_IMP(a_zero_dir_sat, clk, rst, res_valid && !res.total_reflect && res.trans_x == 16'sd0 && res.trans_y == 16'sd0 && res.trans_z == 16'sd0, res.trans_scale == 16'hffff)
  `RDU_ASSERT_NXT(a_pipe_hold, clk, rst, ray_stall && v7, v7)

endmodule
